// ===== rtl/frame_interval_jitter_cv_core_defines.svh =====
// assertion macros used by the checker
`ifndef FRAME_INTERVAL_JITTER_CV_CORE_DEFINES_SVH
`define FRAME_INTERVAL_JITTER_CV_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define FIJCV_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define FIJCV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fijcv_pkg.sv =====
package fijcv_pkg;

	localparam int MAX_WINDOW    = 64;
	localparam int INTERVAL_BITS = 24;

	localparam int STAMP_W  = 64;
	localparam int WIN_W    = 7;
	localparam int SC_W     = 7;
	localparam int CV_W     = 21;
	localparam int STATUS_W = 2;

	localparam int DIGIT_W = 8;
	localparam int DIGITS  = STAMP_W / DIGIT_W;
	localparam int SEQ_W   = $clog2((DIGITS > INTERVAL_BITS) ? DIGITS : INTERVAL_BITS);

	localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
	localparam int PHASE_W = $clog2(MAX_WINDOW);
	localparam int SUM_W   = INTERVAL_BITS + PHASE_W;
	localparam int SQ_W    = 2 * (INTERVAL_BITS - 1) + PHASE_W + 1;

	localparam int CV_LIMIT = 1000000;
	localparam int unsigned CV_SCALE = 400000000;
	localparam int K_W    = $clog2(CV_SCALE);
	localparam int S_W    = SUM_W;
	localparam int D_W    = S_W + 1;
	localparam int V_W    = CNT_W + SQ_W;
	localparam int ROOT_W = (V_W + K_W + 1) / 2;
	localparam int X_W    = 2 * ROOT_W;
	localparam int R_W    = ROOT_W + 3;
	localparam int NUM_W  = ROOT_W + 1;
	localparam int CVC_W  = $clog2(NUM_W);

	localparam logic [STATUS_W-1:0] ST_VALID     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO_MEAN = 2'd2;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [SUM_W-1:0] sum;
		logic [SQ_W-1:0]  sq;
	} cv_req_t;

	typedef struct packed {
		logic [CV_W-1:0]     cv;
		logic [STATUS_W-1:0] status;
	} cv_rsp_t;

endpackage

// ===== rtl/fijcv_cv.sv =====
module fijcv_cv (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  fijcv_pkg::cv_req_t req,
	output logic              done,
	output fijcv_pkg::cv_rsp_t rsp
);

	localparam logic [2:0] CV_IDLE = 3'd0;
	localparam logic [2:0] CV_NQ   = 3'd1;
	localparam logic [2:0] CV_S2   = 3'd2;
	localparam logic [2:0] CV_X    = 3'd3;
	localparam logic [2:0] CV_SQRT = 3'd4;
	localparam logic [2:0] CV_DIV  = 3'd5;
	localparam logic [2:0] CV_DONE = 3'd6;

	logic [2:0]                        state_q;
	logic                              done_q;
	logic [fijcv_pkg::CVC_W-1:0]       cnt_q;
	logic                              neg_q;
	logic [fijcv_pkg::STATUS_W-1:0]    status_q;
	logic [fijcv_pkg::S_W-1:0]         s_q;
	logic [fijcv_pkg::X_W-1:0]         acc_q;
	logic [fijcv_pkg::X_W-1:0]         mcand_q;
	logic [fijcv_pkg::S_W-1:0]         mplier_q;
	logic [fijcv_pkg::R_W-1:0]         rem_q;
	logic [fijcv_pkg::ROOT_W-1:0]      root_q;
	logic [fijcv_pkg::NUM_W-1:0]       quo_q;
	logic [fijcv_pkg::D_W-1:0]         drem_q;
	fijcv_pkg::cv_rsp_t                rsp_q;

	logic [fijcv_pkg::S_W-1:0]    s_in;
	logic                         req_empty;
	logic                         req_zero;
	logic [fijcv_pkg::X_W-1:0]    pp;
	logic [fijcv_pkg::X_W-1:0]    acc_add;
	logic [fijcv_pkg::X_W-1:0]    acc_sub;
	logic [fijcv_pkg::X_W-1:0]    v_val;
	logic [fijcv_pkg::R_W-1:0]    r2;
	logic [fijcv_pkg::R_W-1:0]    t;
	logic                         sq_ge;
	logic [fijcv_pkg::ROOT_W-1:0] root_nxt;
	logic [fijcv_pkg::NUM_W-1:0]  num;
	logic [fijcv_pkg::D_W-1:0]    dvs;
	logic [fijcv_pkg::D_W:0]      dr2;
	logic [fijcv_pkg::D_W:0]      dr_diff;
	logic                         div_ge;
	logic [fijcv_pkg::CV_W-1:0]   cap;
	logic [fijcv_pkg::CV_W-1:0]   cv_fin;

	assign s_in = req.sum[fijcv_pkg::SUM_W-1] ?
		(~req.sum + fijcv_pkg::SUM_W'(1)) : req.sum;
	assign req_empty = (req.count == '0);
	assign req_zero  = (req.sum == '0);

	// shift-add (or shift-subtract) multiply, one multiplier bit per cycle
	assign pp      = mplier_q[0] ? mcand_q : '0;
	assign acc_add = acc_q + pp;
	assign acc_sub = acc_q - pp;
	assign v_val   = acc_sub[fijcv_pkg::X_W-1] ? '0 : acc_sub;

	// restoring square root, two radicand bits per cycle
	assign r2       = {rem_q[fijcv_pkg::R_W-3:0], acc_q[fijcv_pkg::X_W-1 -: 2]};
	assign t        = {1'b0, root_q, 2'b01};
	assign sq_ge    = (r2 >= t);
	assign root_nxt = {root_q[fijcv_pkg::ROOT_W-2:0], sq_ge};
	assign num      = {1'b0, root_nxt} + fijcv_pkg::NUM_W'(s_q);

	// restoring divide, one quotient bit per cycle
	assign dvs     = {s_q, 1'b0};
	assign dr2     = {drem_q, quo_q[fijcv_pkg::NUM_W-1]};
	assign div_ge  = (dr2 >= {1'b0, dvs});
	assign dr_diff = dr2 - {1'b0, dvs};

	assign cap = (quo_q > fijcv_pkg::NUM_W'(fijcv_pkg::CV_LIMIT)) ?
		fijcv_pkg::CV_W'(fijcv_pkg::CV_LIMIT) : quo_q[fijcv_pkg::CV_W-1:0];

	always_comb begin
		if (status_q != fijcv_pkg::ST_VALID) begin
			cv_fin = '0;
		end else if (neg_q) begin
			cv_fin = ~cap + fijcv_pkg::CV_W'(1);
		end else begin
			cv_fin = cap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CV_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				CV_IDLE: begin
					if (start) begin
						state_q <= (req_empty || req_zero) ? CV_DONE : CV_NQ;
					end
				end
				CV_NQ: begin
					if (cnt_q == '0) state_q <= CV_S2;
				end
				CV_S2: begin
					if (cnt_q == '0) state_q <= CV_X;
				end
				CV_X: begin
					if (cnt_q == '0) state_q <= CV_SQRT;
				end
				CV_SQRT: begin
					if (cnt_q == '0) state_q <= CV_DIV;
				end
				CV_DIV: begin
					if (cnt_q == '0) state_q <= CV_DONE;
				end
				CV_DONE: begin
					done_q  <= 1'b1;
					state_q <= CV_IDLE;
				end
				default: begin
					state_q <= CV_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			CV_IDLE: begin
				if (start) begin
					neg_q    <= req.sum[fijcv_pkg::SUM_W-1];
					s_q      <= s_in;
					acc_q    <= '0;
					mcand_q  <= fijcv_pkg::X_W'(req.sq);
					mplier_q <= fijcv_pkg::S_W'(req.count);
					cnt_q    <= fijcv_pkg::CVC_W'(fijcv_pkg::CNT_W - 1);
					if (req_empty) begin
						status_q <= fijcv_pkg::ST_EMPTY;
					end else if (req_zero) begin
						status_q <= fijcv_pkg::ST_ZERO_MEAN;
					end else begin
						status_q <= fijcv_pkg::ST_VALID;
					end
				end
			end
			CV_NQ: begin
				acc_q <= acc_add;
				if (cnt_q == '0) begin
					mcand_q  <= fijcv_pkg::X_W'(s_q);
					mplier_q <= s_q;
					cnt_q    <= fijcv_pkg::CVC_W'(fijcv_pkg::S_W - 1);
				end else begin
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q - 1'b1;
				end
			end
			CV_S2: begin
				if (cnt_q == '0) begin
					acc_q    <= '0;
					mcand_q  <= v_val;
					mplier_q <= fijcv_pkg::S_W'(fijcv_pkg::CV_SCALE);
					cnt_q    <= fijcv_pkg::CVC_W'(fijcv_pkg::K_W - 1);
				end else begin
					acc_q    <= acc_sub;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q - 1'b1;
				end
			end
			CV_X: begin
				acc_q <= acc_add;
				if (cnt_q == '0) begin
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= fijcv_pkg::CVC_W'(fijcv_pkg::ROOT_W - 1);
				end else begin
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q - 1'b1;
				end
			end
			CV_SQRT: begin
				rem_q  <= sq_ge ? (r2 - t) : r2;
				root_q <= root_nxt;
				acc_q  <= acc_q << 2;
				if (cnt_q == '0) begin
					quo_q  <= num;
					drem_q <= '0;
					cnt_q  <= fijcv_pkg::CVC_W'(fijcv_pkg::NUM_W - 1);
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			CV_DIV: begin
				drem_q <= div_ge ? dr_diff[fijcv_pkg::D_W-1:0] : dr2[fijcv_pkg::D_W-1:0];
				quo_q  <= {quo_q[fijcv_pkg::NUM_W-2:0], div_ge};
				cnt_q  <= cnt_q - 1'b1;
			end
			CV_DONE: begin
				rsp_q.cv     <= cv_fin;
				rsp_q.status <= status_q;
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== rtl/frame_interval_jitter_cv_core.sv =====
// one frame in flight; with a nonzero previous timestamp a frame runs the interval subtract
// digit by digit, then saturation and bit-serial squaring; without one it skips all three
// a reporting frame adds bit-serial multiply, square root and divide (skipped for an empty
// or zero-mean window); its report rises together with the next ready
// an unread report holds the next reporting frame in its last state
// arst_n clears phase, previous timestamp, sums and sample count; the window length resets to 25
module frame_interval_jitter_cv_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [fijcv_pkg::STAMP_W-1:0]  frame_stamp,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [fijcv_pkg::STAMP_W-1:0]  report_stamp,
	output logic signed [fijcv_pkg::CV_W-1:0]     cv_centi_percent,
	output logic [fijcv_pkg::SC_W-1:0]            sample_count,
	output logic [fijcv_pkg::STATUS_W-1:0]        report_status,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [fijcv_pkg::WIN_W-1:0]           window_frames
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SUB  = 3'd1;
	localparam logic [2:0] S_SAT  = 3'd2;
	localparam logic [2:0] S_SQR  = 3'd3;
	localparam logic [2:0] S_POST = 3'd4;
	localparam logic [2:0] S_CV   = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	localparam int IB = fijcv_pkg::INTERVAL_BITS;
	localparam int SW = fijcv_pkg::STAMP_W;
	localparam int DW = fijcv_pkg::DIGIT_W;

	logic [2:0]                      state_q;
	logic [fijcv_pkg::SEQ_W-1:0]     seq_q;
	logic [SW-1:0]                   stamp_q;
	logic [SW-1:0]                   a_sh_q;
	logic [SW-1:0]                   b_sh_q;
	logic                            carry_q;
	logic [SW-1:0]                   diff_q;
	logic [SW-1:0]                   prev_q;
	logic [fijcv_pkg::PHASE_W-1:0]   phase_q;
	logic [fijcv_pkg::SUM_W-1:0]     sum_q;
	logic [fijcv_pkg::SQ_W-1:0]      sq_q;
	logic [fijcv_pkg::CNT_W-1:0]     count_q;
	logic [fijcv_pkg::SQ_W-1:0]      mcand_q;
	logic [IB-1:0]                   mplier_q;
	logic                            rep_q;
	logic [fijcv_pkg::WIN_W-1:0]     window_q;
	logic                            out_valid_q;

	logic [DW:0]                     dsum;
	logic                            diff_neg;
	logic                            hi_ones;
	logic                            hi_any;
	logic [IB-1:0]                   d_val;
	logic [IB-1:0]                   mag_val;
	logic [fijcv_pkg::SUM_W-1:0]     sum_nxt;
	logic [fijcv_pkg::SQ_W-1:0]      pp;
	logic [fijcv_pkg::CNT_W-1:0]     win_len;
	logic [fijcv_pkg::CNT_W-1:0]     phase_inc;
	logic [fijcv_pkg::PHASE_W-1:0]   phase_nxt;
	logic                            fin_go;
	logic                            load_rep;
	logic                            cv_start;
	logic                            cv_done;
	fijcv_pkg::cv_req_t              cv_req;
	fijcv_pkg::cv_rsp_t              cv_rsp;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	// interval subtract, one digit per cycle, low digit first
	assign dsum = {1'b0, a_sh_q[DW-1:0]} + {1'b0, ~b_sh_q[DW-1:0]}
		+ {{DW{1'b0}}, carry_q};

	// sign of the exact 65-bit difference
	assign diff_neg = stamp_q[SW-1] ^ ~prev_q[SW-1] ^ carry_q;
	assign hi_ones  = &diff_q[SW-1:IB-1];
	assign hi_any   = |diff_q[SW-1:IB-1];

	always_comb begin
		if (diff_neg) begin
			if (hi_ones) begin
				d_val   = diff_q[IB-1:0];
				mag_val = ~diff_q[IB-1:0] + IB'(1);
			end else begin
				d_val   = {1'b1, {(IB-1){1'b0}}};
				mag_val = {1'b1, {(IB-1){1'b0}}};
			end
		end else if (hi_any) begin
			d_val   = {1'b0, {(IB-1){1'b1}}};
			mag_val = {1'b0, {(IB-1){1'b1}}};
		end else begin
			d_val   = diff_q[IB-1:0];
			mag_val = diff_q[IB-1:0];
		end
	end

	assign sum_nxt = sum_q + {{(fijcv_pkg::SUM_W-IB){d_val[IB-1]}}, d_val};
	assign pp      = mplier_q[0] ? mcand_q : '0;

	always_comb begin
		if (window_q == '0) begin
			win_len = fijcv_pkg::CNT_W'(1);
		end else if (int'(window_q) > fijcv_pkg::MAX_WINDOW) begin
			win_len = fijcv_pkg::CNT_W'(fijcv_pkg::MAX_WINDOW);
		end else begin
			win_len = fijcv_pkg::CNT_W'(window_q);
		end
	end

	assign phase_inc = fijcv_pkg::CNT_W'(phase_q) + fijcv_pkg::CNT_W'(1);
	assign phase_nxt = (phase_inc >= win_len) ? '0 : phase_inc[fijcv_pkg::PHASE_W-1:0];

	// report waits here only while the previous one is still unread
	assign fin_go   = (state_q == S_FIN) && !(rep_q && out_valid_q && !out_ready);
	assign load_rep = fin_go && rep_q;
	assign cv_start = (state_q == S_POST) && (phase_q == '0);

	assign cv_req.count = count_q;
	assign cv_req.sum   = sum_q;
	assign cv_req.sq    = sq_q;

	fijcv_cv u_cv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cv_start),
		.req    (cv_req),
		.done   (cv_done),
		.rsp    (cv_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prev_q      <= '0;
			phase_q     <= '0;
			sum_q       <= '0;
			sq_q        <= '0;
			count_q     <= '0;
			rep_q       <= 1'b0;
			window_q    <= fijcv_pkg::WIN_W'(25);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) window_q <= window_frames;
			if (load_rep) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= (prev_q != '0) ? S_SUB : S_POST;
				end
				S_SUB: begin
					if (seq_q == '0) state_q <= S_SAT;
				end
				S_SAT: begin
					sum_q   <= sum_nxt;
					count_q <= count_q + fijcv_pkg::CNT_W'(1);
					state_q <= S_SQR;
				end
				S_SQR: begin
					sq_q <= sq_q + pp;
					if (seq_q == '0) state_q <= S_POST;
				end
				S_POST: begin
					rep_q   <= (phase_q == '0);
					state_q <= (phase_q == '0) ? S_CV : S_FIN;
				end
				S_CV: begin
					if (cv_done) state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_go) begin
						prev_q  <= stamp_q;
						phase_q <= phase_nxt;
						if (rep_q) begin
							sum_q   <= '0;
							sq_q    <= '0;
							count_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					stamp_q <= frame_stamp;
					a_sh_q  <= frame_stamp;
					b_sh_q  <= prev_q;
					carry_q <= 1'b1;
					seq_q   <= fijcv_pkg::SEQ_W'(fijcv_pkg::DIGITS - 1);
				end
			end
			S_SUB: begin
				diff_q  <= {dsum[DW-1:0], diff_q[SW-1:DW]};
				a_sh_q  <= a_sh_q >> DW;
				b_sh_q  <= b_sh_q >> DW;
				carry_q <= dsum[DW];
				seq_q   <= seq_q - 1'b1;
			end
			S_SAT: begin
				mcand_q  <= fijcv_pkg::SQ_W'(mag_val);
				mplier_q <= mag_val;
				seq_q    <= fijcv_pkg::SEQ_W'(IB - 1);
			end
			S_SQR: begin
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				seq_q    <= seq_q - 1'b1;
			end
			S_FIN: begin
				if (fin_go && rep_q) begin
					report_stamp     <= stamp_q;
					cv_centi_percent <= cv_rsp.cv;
					sample_count     <= fijcv_pkg::SC_W'(count_q);
					report_status    <= cv_rsp.status;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/fijcv_checker.sv =====
`include "frame_interval_jitter_cv_core_defines.svh"

module fijcv_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [fijcv_pkg::STAMP_W-1:0]  report_stamp,
	input logic signed [fijcv_pkg::CV_W-1:0]     cv_centi_percent,
	input logic [fijcv_pkg::SC_W-1:0]            sample_count,
	input logic [fijcv_pkg::STATUS_W-1:0]        report_status
);

	`FIJCV_ASSERT_NEXT(a_report_hold, out_valid && !out_ready, out_valid && $stable(report_stamp) && $stable(cv_centi_percent), "stalled report dropped or changed")

	`FIJCV_ASSERT_IMPL(a_empty_window, out_valid && report_status == fijcv_pkg::ST_EMPTY, cv_centi_percent == '0 && sample_count == '0, "empty window report carries data")

	`FIJCV_ASSERT_IMPL(a_zero_mean, out_valid && report_status == fijcv_pkg::ST_ZERO_MEAN, cv_centi_percent == '0 && sample_count != '0, "zero mean report malformed")

	`FIJCV_ASSERT_IMPL(a_cv_range, out_valid && report_status == fijcv_pkg::ST_VALID, sample_count != '0 && cv_centi_percent <= fijcv_pkg::CV_LIMIT && cv_centi_percent >= -fijcv_pkg::CV_LIMIT, "valid report out of range")

endmodule

bind frame_interval_jitter_cv_core fijcv_checker u_fijcv_checker (.*);
